@@ rtl/core/ptd_pkg.sv @@
// Shared types and codes for the periodic task dispatcher.
// Holds the request and result structs, the per-task record and the code constants.
// No dependencies.
package ptd_pkg;

   // Request modes.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_DONE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   // Result kinds.
   localparam logic [2:0] K_DISPATCH = 3'd0;
   localparam logic [2:0] K_FAULT    = 3'd1;
   localparam logic [2:0] K_TICKDONE = 3'd2;
   localparam logic [2:0] K_DONE_OK  = 3'd3;
   localparam logic [2:0] K_OVERRUN  = 3'd4;
   localparam logic [2:0] K_READ     = 3'd5;
   localparam logic [2:0] K_RESET    = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_HANDLER  = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;
   localparam logic [1:0] CSR_BUDGET   = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
      logic [1:0]  task_index;
      logic [31:0] runtime_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  task_index_res;
      logic [31:0] run_count;
      logic [31:0] last_runtime;
      logic [31:0] max_runtime;
      logic [31:0] total_runtime;
      logic [31:0] overrun_count;
      logic [31:0] all_runs;
      logic [31:0] all_overruns;
      logic [31:0] tick_count;
      logic [31:0] stamp_ms;
      logic        last;
   } rsp_type;

   // One task record as it is held in the task memory.
   typedef struct packed {
      logic [31:0] last_run;
      logic [31:0] runs;
      logic [31:0] last_rt;
      logic [31:0] max_rt;
      logic [31:0] total_rt;
      logic [31:0] overruns;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

@@ rtl/core/periodic_task_dispatcher.sv @@
// Top level of the periodic task dispatcher: sequencer, configuration and output register.
// Depends on ptd_pkg and ptd_ram.
//
//   channel | ports                              | direction
//   request | req_valid req_ready req_data       | in
//   result  | rsp_valid rsp_ready rsp_data       | out
//   config  | csr_valid csr_ready csr_index csr_data | in
//
// A tick is accepted, then takes a memory read and a check and emit step for each task, then
// tick done; completion and read take a memory read and an emit step, and a statistics reset
// writes each record in turn, then reset done. The task record memory has a registered read.
// Reset clears control state and marks every record as empty; empty records read as zero.
// A full output register stalls the sequencer; one request is in work at a time.
module periodic_task_dispatcher #(
   parameter int NUM_TASKS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ptd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ptd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data
);

   localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [AW-1:0] T_LAST = AW'(NUM_TASKS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_T_RD, S_T_EX, S_T_DONE, S_C_RD, S_C_EX,
      S_Z_WR, S_Z_DONE, S_R_RD, S_R_EX
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     t_ff, t_in;
   ptd_pkg::req_type  cur_ff, cur_in;
   logic              rdv_ff, rdv_in;
   logic [NUM_TASKS-1:0] vld_ff, vld_in;
   logic [31:0]       tick_ff, tick_in;
   logic [31:0]       gruns_ff, gruns_in;
   logic [31:0]       govr_ff, govr_in;
   logic [3:0]        en_ff, hnd_ff;
   logic [63:0]       intv_ff, bud_ff;
   ptd_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   ptd_pkg::rec_type  ram_wdata, ram_rdata, rec, upd;
   logic [ptd_pkg::REC_W-1:0] ram_rbits;

   logic              out_free, load;
   logic [1:0]        tsel;
   logic [15:0]       iv, bud;
   logic [31:0]       elapsed;
   logic              due, ovr;
   logic [AW-1:0]     idx_clamp;

   ptd_ram #(.WIDTH(ptd_pkg::REC_W), .DEPTH(NUM_TASKS), .AW(AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   assign ram_rdata = ptd_pkg::rec_type'(ram_rbits);
   // Records never written since reset read as zero.
   assign rec       = rdv_ff ? ram_rdata : '0;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Out-of-range task indexes address task 0.
   assign idx_clamp = (int'(req_data.task_index) >= NUM_TASKS) ? '0 : AW'(req_data.task_index);

   // Per-task configuration fields of the task in work.
   assign tsel    = 2'(t_ff);
   assign iv      = intv_ff[16*tsel +: 16];
   assign bud     = bud_ff[16*tsel +: 16];
   assign elapsed = cur_ff.now_ms - rec.last_run;
   assign due     = en_ff[tsel] && ((iv == 16'd0) || (elapsed >= {16'd0, iv}));
   assign ovr     = (bud != 16'd0) && (cur_ff.runtime_us > {16'd0, bud});

   // Completion update of the record.
   always_comb begin
      upd          = rec;
      upd.runs     = rec.runs + 32'd1;
      upd.last_rt  = cur_ff.runtime_us;
      upd.total_rt = rec.total_rt + cur_ff.runtime_us;
      if (cur_ff.runtime_us > rec.max_rt) begin
         upd.max_rt = cur_ff.runtime_us;
      end
      if (ovr) begin
         upd.overruns = rec.overruns + 32'd1;
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      cur_in       = cur_ff;
      rdv_in       = rdv_ff;
      vld_in       = vld_ff;
      tick_in      = tick_ff;
      gruns_in     = gruns_ff;
      govr_in      = govr_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = t_ff;
      ram_raddr    = t_ff;
      ram_wdata    = rec;
      load         = 1'b0;
      rsp_in       = '0;
      rsp_in.all_runs     = gruns_ff;
      rsp_in.all_overruns = govr_ff;
      rsp_in.tick_count   = tick_ff;
      rsp_in.task_index_res = tsel;
      rsp_in.run_count     = rec.runs;
      rsp_in.last_runtime  = rec.last_rt;
      rsp_in.max_runtime   = rec.max_rt;
      rsp_in.total_runtime = rec.total_rt;
      rsp_in.overrun_count = rec.overruns;
      rsp_in.stamp_ms      = rec.last_run;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in = req_data;
               unique case (req_data.mode)
                  ptd_pkg::MODE_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     t_in     = '0;
                     state_in = S_T_RD;
                  end
                  ptd_pkg::MODE_DONE: begin
                     t_in     = idx_clamp;
                     state_in = S_C_RD;
                  end
                  ptd_pkg::MODE_CLEAR: begin
                     tick_in  = '0;
                     gruns_in = '0;
                     govr_in  = '0;
                     t_in     = '0;
                     state_in = S_Z_WR;
                  end
                  default: begin
                     t_in     = idx_clamp;
                     state_in = S_R_RD;
                  end
               endcase
            end
         end
         S_T_RD, S_C_RD, S_R_RD: begin
            ram_re = 1'b1;
            rdv_in = vld_ff[t_ff];
            unique case (state_ff)
               S_T_RD:  state_in = S_T_EX;
               S_C_RD:  state_in = S_C_EX;
               default: state_in = S_R_EX;
            endcase
         end
         S_T_EX: begin
            if (!due || out_free) begin
               if (due) begin
                  load = 1'b1;
                  if (hnd_ff[tsel]) begin
                     ram_we             = 1'b1;
                     ram_wdata.last_run = cur_ff.now_ms;
                     vld_in[t_ff]       = 1'b1;
                     rsp_in.kind        = ptd_pkg::K_DISPATCH;
                     rsp_in.stamp_ms    = cur_ff.now_ms;
                  end else begin
                     rsp_in.kind = ptd_pkg::K_FAULT;
                  end
               end
               if (t_ff == T_LAST) begin
                  state_in = S_T_DONE;
               end else begin
                  t_in     = t_ff + AW'(1);
                  state_in = S_T_RD;
               end
            end
         end
         S_T_DONE, S_Z_DONE: begin
            if (out_free) begin
               load   = 1'b1;
               rsp_in = '0;
               rsp_in.kind         = (state_ff == S_T_DONE) ? ptd_pkg::K_TICKDONE
                                                            : ptd_pkg::K_RESET;
               rsp_in.all_runs     = gruns_ff;
               rsp_in.all_overruns = govr_ff;
               rsp_in.tick_count   = tick_ff;
               rsp_in.stamp_ms     = cur_ff.now_ms;
               rsp_in.last         = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_C_EX: begin
            if (out_free) begin
               load         = 1'b1;
               ram_we       = 1'b1;
               ram_wdata    = upd;
               vld_in[t_ff] = 1'b1;
               gruns_in     = gruns_ff + 32'd1;
               govr_in      = govr_ff + {31'd0, ovr};
               rsp_in.kind          = ovr ? ptd_pkg::K_OVERRUN : ptd_pkg::K_DONE_OK;
               rsp_in.run_count     = upd.runs;
               rsp_in.last_runtime  = upd.last_rt;
               rsp_in.max_runtime   = upd.max_rt;
               rsp_in.total_runtime = upd.total_rt;
               rsp_in.overrun_count = upd.overruns;
               rsp_in.all_runs      = gruns_ff + 32'd1;
               rsp_in.all_overruns  = govr_ff + {31'd0, ovr};
               rsp_in.stamp_ms      = ovr ? cur_ff.now_ms : rec.last_run;
               rsp_in.last          = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_Z_WR: begin
            ram_we             = 1'b1;
            ram_wdata          = '0;
            ram_wdata.last_run = cur_ff.now_ms;
            vld_in[t_ff]       = 1'b1;
            if (t_ff == T_LAST) begin
               state_in = S_Z_DONE;
            end else begin
               t_in = t_ff + AW'(1);
            end
         end
         S_R_EX: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_in.kind = ptd_pkg::K_READ;
               rsp_in.last = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register valid.
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State, counters, configuration and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         t_ff         <= '0;
         rdv_ff       <= 1'b0;
         vld_ff       <= '0;
         tick_ff      <= '0;
         gruns_ff     <= '0;
         govr_ff      <= '0;
         en_ff        <= '0;
         hnd_ff       <= 4'hF;
         intv_ff      <= '0;
         bud_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         rdv_ff       <= rdv_in;
         vld_ff       <= vld_in;
         tick_ff      <= tick_in;
         gruns_ff     <= gruns_in;
         govr_ff      <= govr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               ptd_pkg::CSR_ENABLE:   en_ff   <= csr_data[3:0];
               ptd_pkg::CSR_HANDLER:  hnd_ff  <= csr_data[3:0];
               ptd_pkg::CSR_INTERVAL: intv_ff <= csr_data;
               default:               bud_ff  <= csr_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Only one request is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // Tick done always closes a tick.
   a_tickdone_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == ptd_pkg::K_TICKDONE |-> rsp_data.last)
      else $error("tick done result without last");

   // A statistics reset reports cleared global counters.
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == ptd_pkg::K_RESET
      |-> rsp_data.tick_count == 32'd0 && rsp_data.all_runs == 32'd0)
      else $error("reset done result with nonzero counters");

endmodule

@@ rtl/core/ptd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
